>>> hw/rtl/wsalu_pkg.sv
`timescale 1ns / 1ps

package wsalu_pkg;

  localparam int XLEN      = 64;
  localparam int MAX_WIDTH = 64;

  // Commands
  localparam logic [3:0] CMD_ADD   = 4'd0;
  localparam logic [3:0] CMD_SUB   = 4'd1;
  localparam logic [3:0] CMD_MUL   = 4'd2;
  localparam logic [3:0] CMD_DIV   = 4'd3;
  localparam logic [3:0] CMD_CHS   = 4'd4;
  localparam logic [3:0] CMD_ABS   = 4'd5;
  localparam logic [3:0] CMD_SIGN  = 4'd6;
  localparam logic [3:0] CMD_GCD   = 4'd7;
  localparam logic [3:0] CMD_LCM   = 4'd8;
  localparam logic [3:0] CMD_SQRT  = 4'd9;
  localparam logic [3:0] CMD_POW   = 4'd10;
  localparam logic [3:0] CMD_POW2  = 4'd11;
  localparam logic [3:0] CMD_POW10 = 4'd12;
  localparam logic [3:0] CMD_LOG2  = 4'd13;
  localparam logic [3:0] CMD_LOG10 = 4'd14;

  // Number representations
  localparam logic [1:0] MODE_UNS = 2'd0;
  localparam logic [1:0] MODE_TWO = 2'd1;
  localparam logic [1:0] MODE_ONE = 2'd2;
  localparam logic [1:0] MODE_SM  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_DIV0   = 2'd1;
  localparam logic [1:0] ERR_DOMAIN = 2'd2;

  // Configuration register indexes
  localparam logic REG_SIGN_MODE = 1'b0;
  localparam logic REG_WORD_SIZE = 1'b1;

  localparam logic [6:0] WS_RESET = 7'd64;
  localparam logic [4:0] P10_LAST = 5'd19;

  typedef logic [XLEN-1:0] word_t;

  typedef struct packed {
    logic  neg;
    word_t mag;
  } mag_t;

  // Split a word into sign and magnitude
  function automatic mag_t mag_f(word_t v, logic [1:0] mode, word_t wm, word_t sb);
    mag_t  m;
    word_t w;
    w     = v & wm;
    m.neg = 1'b0;
    m.mag = w;
    if (mode != MODE_UNS && (w & sb) != '0) begin
      m.neg = 1'b1;
      case (mode)
        MODE_TWO: m.mag = (word_t'(0) - w) & wm;
        MODE_ONE: m.mag = (~w) & wm;
        default:  m.mag = (w ^ sb) & wm;
      endcase
    end
    return m;
  endfunction

  // Build a word from magnitude and sign
  function automatic word_t compose_f(word_t m, logic neg, logic [1:0] mode,
                                     word_t wm, word_t sb);
    word_t w;
    word_t r;
    w = m & wm;
    if (!neg || mode == MODE_UNS) begin
      r = w;
    end else begin
      case (mode)
        MODE_TWO: r = (word_t'(0) - w) & wm;
        MODE_ONE: r = (~w) & wm;
        default:  r = w | sb;
      endcase
    end
    return r;
  endfunction

  // Signed value of a sign-magnitude word
  function automatic word_t sm_f(word_t v, word_t sb);
    word_t r;
    r = ((v & sb) != '0) ? (word_t'(0) - (v ^ sb)) : v;
    return r;
  endfunction

  // Overflow of a magnitude add with like signs
  function automatic logic add_ov_f(word_t xv, word_t yv, logic neg, logic [1:0] mode,
                                    word_t sb);
    word_t      u;
    logic [1:0] hits;
    logic       ov;
    ov = 1'b0;
    if (mode == MODE_UNS) begin
      u    = (yv & (sb - 1'b1)) + (xv & (sb - 1'b1));
      hits = 2'((u & sb) != '0) + 2'((xv & sb) != '0) + 2'((yv & sb) != '0);
      ov   = hits > 2'd1;
    end else if (mode == MODE_TWO) begin
      u = xv + yv;
      if (!(neg && u == sb)) begin
        ov = ((u & sb) != '0) || (xv == sb && yv != '0) || (yv == sb && xv != '0);
      end
    end else begin
      ov = (sb & (xv + yv)) != '0;
    end
    return ov;
  endfunction

  // Powers of ten up to 10^19
  function automatic word_t p10_f(logic [4:0] i);
    word_t r;
    case (i)
      5'd0:    r = 64'd1;
      5'd1:    r = 64'd10;
      5'd2:    r = 64'd100;
      5'd3:    r = 64'd1000;
      5'd4:    r = 64'd10000;
      5'd5:    r = 64'd100000;
      5'd6:    r = 64'd1000000;
      5'd7:    r = 64'd10000000;
      5'd8:    r = 64'd100000000;
      5'd9:    r = 64'd1000000000;
      5'd10:   r = 64'd10000000000;
      5'd11:   r = 64'd100000000000;
      5'd12:   r = 64'd1000000000000;
      5'd13:   r = 64'd10000000000000;
      5'd14:   r = 64'd100000000000000;
      5'd15:   r = 64'd1000000000000000;
      5'd16:   r = 64'd10000000000000000;
      5'd17:   r = 64'd100000000000000000;
      5'd18:   r = 64'd1000000000000000000;
      5'd19:   r = 64'd10000000000000000000;
      default: r = '1;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/word_size_integer_alu.sv
`timescale 1ns / 1ps
// Add, sub, chs, abs, sign and 2^x complete in the execute state; mul, div, sqrt,
// log2, log10, gcd and lcm run through iterative states, and y^x and 10^x repeat
// the multiply for each square and multiply step.
// Throughput: one command at a time; busy stays high until
// the result beat. The multiply uses one 32x32 multiplier over four partial products.
// Reset: synchronous active low; sign_mode two's complement, word_size 64, flags clear.
module word_size_integer_alu (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [3:0]           in_command,
  input  wsalu_pkg::word_t     in_y_operand,
  input  wsalu_pkg::word_t     in_x_operand,
  output logic                 out_valid,
  output wsalu_pkg::word_t     out_result_word,
  output logic                 out_carry_out,
  output logic                 out_overflow_out,
  output logic [1:0]           out_error_code,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_wdata
);
  import wsalu_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_MAG   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_MPOST = 4'd4;
  localparam logic [3:0] S_PWR   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DPOST = 4'd7;
  localparam logic [3:0] S_GCD   = 4'd8;
  localparam logic [3:0] S_GSHL  = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_LOG2  = 4'd11;
  localparam logic [3:0] S_LOG10 = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]   state_r, state_nxt;
  logic [1:0]   sign_mode_r;
  logic [6:0]   word_size_r;
  logic         carry_r, carry_nxt;
  logic         ovf_r, ovf_nxt;
  logic [3:0]   cmd_r, cmd_nxt;
  word_t        y_r, y_nxt, x_r, x_nxt, vx_r, vx_nxt, vy_r, vy_nxt;
  logic         sx_r, sx_nxt, sy_r, sy_nxt;
  word_t        wa_r, wa_nxt, wb_r, wb_nxt, wc_r, wc_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  word_t        ma_r, ma_nxt, mb_r, mb_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  pp_r, pp_nxt;
  logic         sgn_r, sgn_nxt;
  logic         sq_r, sq_nxt;
  logic         ovacc_r, ovacc_nxt, ovnx_r, ovnx_nxt;
  word_t        res_r, res_nxt;
  logic [1:0]   err_r, err_nxt;

  // Geometry from the configured word size
  logic [6:0]   ws;
  word_t        wmask, sbit, top;
  logic         signed_mode;

  always_comb begin
    if (word_size_r == 7'd0) begin
      ws = 7'd1;
    end else if (word_size_r > 7'(MAX_WIDTH)) begin
      ws = 7'(MAX_WIDTH);
    end else begin
      ws = word_size_r;
    end
  end

  assign wmask       = ~({XLEN{1'b1}} << ws);
  assign sbit        = word_t'(1) << (ws - 7'd1);
  assign signed_mode = sign_mode_r != MODE_UNS;
  assign top         = signed_mode ? sbit : '0;

  // Operand capture
  mag_t in_mx, in_my;
  assign in_mx = mag_f(in_x_operand, sign_mode_r, wmask, sbit);
  assign in_my = mag_f(in_y_operand, sign_mode_r, wmask, sbit);

  // Combinational datapath for the short commands
  word_t add_s, add_s1, sub_s, sub_s1, smadd_s, smsub_s;
  logic  add_ov, sub_ov;
  logic  [6:0] lim;
  assign add_s   = y_r + x_r;
  assign add_s1  = y_r + x_r + 64'd1;
  assign sub_s   = y_r - x_r;
  assign sub_s1  = y_r - x_r - 64'd1;
  assign smadd_s = sm_f(y_r, sbit) + sm_f(x_r, sbit);
  assign smsub_s = sm_f(y_r, sbit) - sm_f(x_r, sbit);
  assign add_ov  = (sx_r == sy_r) ? add_ov_f(vx_r, vy_r, sx_r, sign_mode_r, sbit) : 1'b0;
  assign sub_ov  = (sx_r != sy_r) ? add_ov_f(vx_r, vy_r, sy_r, sign_mode_r, sbit) : 1'b0;
  assign lim     = signed_mode ? (ws - 7'd1) : ws;

  // Multiplier partial product and accumulate
  logic [31:0]  pa, pb;
  logic [1:0]   pk;
  logic [127:0] pp_sh;
  word_t        p64;
  logic         mchk;
  assign pa = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign pb = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pk = cnt_r[1:0] - 2'd1;

  always_comb begin
    case (2'(pk[1]) + 2'(pk[0]))
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
  end

  assign p64  = acc_r[63:0] & wmask;
  assign mchk = ((p64 & top) != '0) || (acc_r[127:64] != '0) ||
                ((acc_r[63:0] & ~wmask) != '0);

  // Divider step
  logic [64:0] rem_s, rem_d;
  assign rem_s = {wc_r, wa_r[63]};
  assign rem_d = rem_s - {1'b0, wb_r};

  // Square root step
  word_t sq_t;
  assign sq_t = wb_r + wc_r;

  // Multiply operand words: y and x for mul, quotient and y magnitude for lcm
  mag_t mag_a, mag_b;
  assign mag_a = mag_f((cmd_r == CMD_MUL) ? y_r : wa_r, sign_mode_r, wmask, sbit);
  assign mag_b = mag_f((cmd_r == CMD_MUL) ? x_r : vy_r, sign_mode_r, wmask, sbit);

  logic [4:0] l10_i;
  assign l10_i = cnt_r[4:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    carry_nxt = carry_r;
    ovf_nxt   = ovf_r;
    cmd_nxt   = cmd_r;
    y_nxt     = y_r;
    x_nxt     = x_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    wa_nxt    = wa_r;
    wb_nxt    = wb_r;
    wc_nxt    = wc_r;
    cnt_nxt   = cnt_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    acc_nxt   = acc_r;
    pp_nxt    = pp_r;
    sgn_nxt   = sgn_r;
    sq_nxt    = sq_r;
    ovacc_nxt = ovacc_r;
    ovnx_nxt  = ovnx_r;
    res_nxt   = res_r;
    err_nxt   = err_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command;
          y_nxt     = in_y_operand & wmask;
          x_nxt     = in_x_operand & wmask;
          vx_nxt    = in_mx.mag;
          sx_nxt    = in_mx.neg;
          vy_nxt    = in_my.mag;
          sy_nxt    = in_my.neg;
          res_nxt   = '0;
          err_nxt   = ERR_NONE;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_ADD: begin
            ovf_nxt = add_ov;
            if (sign_mode_r == MODE_SM) begin
              carry_nxt = add_ov;
              res_nxt   = ((smadd_s & sbit) != '0) ? ((word_t'(0) - smadd_s) | sbit)
                                                   : smadd_s;
            end else if ((add_s & wmask) < y_r) begin
              carry_nxt = 1'b1;
              res_nxt   = (sign_mode_r == MODE_ONE) ? add_s1 : add_s;
            end else begin
              carry_nxt = 1'b0;
              res_nxt   = add_s;
            end
          end
          CMD_SUB: begin
            ovf_nxt = sub_ov;
            if (sign_mode_r == MODE_SM) begin
              carry_nxt = (!sx_r && !sy_r && vx_r > vy_r) || (sx_r && sy_r && vx_r < vy_r);
              res_nxt   = ((smsub_s & sbit) != '0) ? ((word_t'(0) - smsub_s) | sbit)
                                                   : smsub_s;
            end else if (y_r < x_r) begin
              carry_nxt = 1'b1;
              if (sign_mode_r == MODE_UNS) begin
                ovf_nxt = 1'b1;
              end
              res_nxt = (sign_mode_r == MODE_ONE) ? sub_s1 : sub_s;
            end else begin
              carry_nxt = 1'b0;
              res_nxt   = sub_s;
            end
          end
          CMD_MUL: begin
            state_nxt = S_MAG;
          end
          CMD_DIV: begin
            if (vx_r == '0) begin
              err_nxt = ERR_DIV0;
            end else begin
              wa_nxt    = vy_r;
              wb_nxt    = vx_r;
              wc_nxt    = '0;
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end
          end
          CMD_CHS: begin
            if (sign_mode_r == MODE_UNS || (sign_mode_r == MODE_TWO && x_r == sbit)) begin
              ovf_nxt = 1'b1;
              res_nxt = word_t'(0) - vx_r;
            end else begin
              ovf_nxt = 1'b0;
              res_nxt = compose_f(vx_r, !sx_r, sign_mode_r, wmask, sbit);
            end
          end
          CMD_ABS: begin
            if (sign_mode_r == MODE_TWO && x_r == sbit) begin
              ovf_nxt = 1'b1;
              res_nxt = x_r;
            end else begin
              ovf_nxt = 1'b0;
              res_nxt = vx_r;
            end
          end
          CMD_SIGN: begin
            res_nxt = (vx_r == '0) ? '0 : compose_f(64'd1, sx_r, sign_mode_r, wmask, sbit);
          end
          CMD_GCD, CMD_LCM: begin
            if (vx_r == '0 || vy_r == '0) begin
              if (cmd_r == CMD_GCD) begin
                res_nxt = (vx_r == '0) ? vy_r : vx_r;
              end
            end else begin
              wa_nxt    = vx_r;
              wb_nxt    = vy_r;
              cnt_nxt   = '0;
              state_nxt = S_GCD;
            end
          end
          CMD_SQRT: begin
            if (sx_r) begin
              err_nxt = ERR_DOMAIN;
            end else if (vx_r != '0) begin
              wa_nxt    = vx_r;
              wb_nxt    = '0;
              wc_nxt    = word_t'(1) << 62;
              state_nxt = S_SQRT;
            end
          end
          CMD_POW: begin
            if (vx_r == '0 && vy_r == '0) begin
              err_nxt = ERR_DOMAIN;
              ovf_nxt = 1'b1;
            end else begin
              carry_nxt = 1'b0;
              ovf_nxt   = 1'b0;
              if (vx_r == '0) begin
                res_nxt = 64'd1;
              end else if (vy_r != '0) begin
                wa_nxt    = 64'd1;
                wb_nxt    = vy_r;
                wc_nxt    = vx_r;
                ovacc_nxt = 1'b0;
                ovnx_nxt  = 1'b0;
                state_nxt = S_PWR;
              end
            end
          end
          CMD_POW2: begin
            ovf_nxt   = 1'b0;
            carry_nxt = sx_r && vx_r == 64'd1;
            if (!(sx_r && vx_r != '0)) begin
              if (vx_r >= word_t'(lim)) begin
                carry_nxt = vx_r == word_t'(lim);
                ovf_nxt   = 1'b1;
              end else begin
                res_nxt = word_t'(1) << vx_r[5:0];
              end
            end
          end
          CMD_POW10: begin
            carry_nxt = 1'b0;
            if (vx_r == '0) begin
              ovf_nxt = 1'b0;
              res_nxt = 64'd1;
            end else if (sx_r) begin
              carry_nxt = 1'b1;
            end else begin
              wa_nxt    = 64'd1;
              wb_nxt    = 64'd10;
              wc_nxt    = x_r;
              ovacc_nxt = ws <= 7'd3 || (signed_mode && ws == 7'd4);
              ovnx_nxt  = 1'b0;
              state_nxt = S_PWR;
            end
          end
          CMD_LOG2: begin
            if (vx_r == '0 || sx_r) begin
              err_nxt = ERR_DOMAIN;
            end else begin
              wa_nxt    = vx_r;
              cnt_nxt   = '0;
              state_nxt = S_LOG2;
            end
          end
          CMD_LOG10: begin
            if (vx_r == '0 || sx_r) begin
              err_nxt = ERR_DOMAIN;
            end else begin
              cnt_nxt   = '0;
              state_nxt = S_LOG10;
            end
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end

      // Take magnitudes of the multiply words and start the multiplier
      S_MAG: begin
        ma_nxt    = mag_a.mag;
        mb_nxt    = mag_b.mag;
        sgn_nxt   = mag_a.neg ^ mag_b.neg;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end

      // Issue four partial products, accumulating each in the cycle after its issue
      S_MUL: begin
        if (cnt_r[2] == 1'b0) begin
          pp_nxt = {32'd0, pa} * {32'd0, pb};
        end
        if (cnt_r[2:0] != 3'd0) begin
          acc_nxt = acc_r + pp_sh;
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r[2]) begin
          state_nxt = S_MPOST;
        end
      end

      S_MPOST: begin
        if (cmd_r == CMD_POW || cmd_r == CMD_POW10) begin
          state_nxt = S_PWR;
          if (sq_r) begin
            wb_nxt   = p64;
            ovnx_nxt = ovnx_r | mchk;
          end else begin
            wa_nxt    = p64;
            ovacc_nxt = ovacc_r | ovnx_r | mchk;
            wc_nxt    = {wc_r[63:1], 1'b0};
          end
        end else begin
          ovf_nxt   = mchk;
          res_nxt   = (sign_mode_r == MODE_UNS) ? p64
                      : compose_f(p64 & ~sbit, sgn_r, sign_mode_r, wmask, sbit);
          state_nxt = S_DONE;
        end
      end

      // Square-and-multiply over the exponent bits
      S_PWR: begin
        if (wc_r == '0) begin
          carry_nxt = 1'b0;
          ovf_nxt   = ovacc_r;
          res_nxt   = (cmd_r == CMD_POW)
                      ? compose_f(wa_r, sy_r && vx_r[0], sign_mode_r, wmask, sbit)
                      : (wa_r & wmask);
          state_nxt = S_DONE;
        end else if (wc_r[0]) begin
          ma_nxt    = wa_r;
          mb_nxt    = wb_r;
          sq_nxt    = 1'b0;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          wc_nxt = wc_r >> 1;
          if (wc_r[63:1] != '0) begin
            ma_nxt    = wb_r;
            mb_nxt    = wb_r;
            sq_nxt    = 1'b1;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_MUL;
          end
        end
      end

      // Restoring division, one quotient bit per cycle
      S_DIV: begin
        if (!rem_d[64]) begin
          wc_nxt = rem_d[63:0];
          wa_nxt = {wa_r[62:0], 1'b1};
        end else begin
          wc_nxt = rem_s[63:0];
          wa_nxt = {wa_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(XLEN - 1)) begin
          state_nxt = S_DPOST;
        end
      end

      S_DPOST: begin
        if (cmd_r == CMD_LCM) begin
          state_nxt = S_MAG;
        end else begin
          ovf_nxt   = 1'b0;
          carry_nxt = (wc_r != '0) || (signed_mode && (wa_r & sbit) != '0);
          if (sign_mode_r == MODE_TWO && sx_r && vx_r == 64'd1 && y_r == sbit) begin
            ovf_nxt = 1'b1;
          end
          res_nxt   = compose_f(wa_r, sx_r ^ sy_r, sign_mode_r, wmask, sbit);
          state_nxt = S_DONE;
        end
      end

      // Binary gcd: strip shared twos, then halve or subtract
      S_GCD: begin
        if (wa_r == wb_r) begin
          state_nxt = S_GSHL;
        end else if (!wa_r[0] && !wb_r[0]) begin
          wa_nxt  = wa_r >> 1;
          wb_nxt  = wb_r >> 1;
          cnt_nxt = cnt_r + 7'd1;
        end else if (!wa_r[0]) begin
          wa_nxt = wa_r >> 1;
        end else if (!wb_r[0]) begin
          wb_nxt = wb_r >> 1;
        end else if (wa_r > wb_r) begin
          wa_nxt = wa_r - wb_r;
        end else begin
          wb_nxt = wb_r - wa_r;
        end
      end

      // Restore the shared twos one bit a cycle
      S_GSHL: begin
        if (cnt_r != '0) begin
          wa_nxt  = wa_r << 1;
          cnt_nxt = cnt_r - 7'd1;
        end else if (cmd_r == CMD_GCD) begin
          res_nxt   = wa_r;
          state_nxt = S_DONE;
        end else begin
          wa_nxt    = vx_r;
          wb_nxt    = wa_r;
          wc_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end

      // Bit-pair square root; remainder left in wa
      S_SQRT: begin
        if (wa_r >= sq_t) begin
          wa_nxt = wa_r - sq_t;
          wb_nxt = (wb_r >> 1) + wc_r;
        end else begin
          wb_nxt = wb_r >> 1;
        end
        wc_nxt = wc_r >> 2;
        if (wc_r[0]) begin
          carry_nxt = wa_nxt != '0;
          res_nxt   = wb_nxt;
          state_nxt = S_DONE;
        end
      end

      S_LOG2: begin
        if (wa_r[63:1] != '0) begin
          wa_nxt  = wa_r >> 1;
          cnt_nxt = cnt_r + 7'd1;
        end else begin
          carry_nxt = (vx_r & (vx_r - 64'd1)) != '0;
          res_nxt   = word_t'(cnt_r);
          state_nxt = S_DONE;
        end
      end

      // Walk the power-of-ten table
      S_LOG10: begin
        if (l10_i < P10_LAST && vx_r >= p10_f(l10_i + 5'd1)) begin
          cnt_nxt = cnt_r + 7'd1;
        end else begin
          carry_nxt = vx_r != p10_f(l10_i);
          res_nxt   = word_t'(cnt_r);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (err_nxt != ERR_NONE) begin
      res_nxt = '0;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sign_mode_r <= MODE_TWO;
      word_size_r <= WS_RESET;
      carry_r     <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      carry_r <= carry_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SIGN_MODE: sign_mode_r <= cfg_wdata[1:0];
          REG_WORD_SIZE: word_size_r <= cfg_wdata;
          default: begin
            sign_mode_r <= sign_mode_r;
          end
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    y_r     <= y_nxt;
    x_r     <= x_nxt;
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    wa_r    <= wa_nxt;
    wb_r    <= wb_nxt;
    wc_r    <= wc_nxt;
    cnt_r   <= cnt_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    acc_r   <= acc_nxt;
    pp_r    <= pp_nxt;
    sgn_r   <= sgn_nxt;
    sq_r    <= sq_nxt;
    ovacc_r <= ovacc_nxt;
    ovnx_r  <= ovnx_nxt;
    res_r   <= res_nxt;
    err_r   <= err_nxt;
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = state_r == S_DONE;
  assign out_result_word  = res_r & wmask;
  assign out_carry_out    = carry_r;
  assign out_overflow_out = ovf_r;
  assign out_error_code   = err_r;

  // Checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted command did not raise busy");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result beat longer than one cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_result_word == '0)
    else $error("error beat with nonzero result");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code == ERR_NONE || out_error_code == ERR_DIV0 ||
                  out_error_code == ERR_DOMAIN)
    else $error("bad error code");

endmodule

>>> verif/tb_word_size_integer_alu.sv
`timescale 1ns / 1ps

module tb_word_size_integer_alu;
  import wsalu_pkg::*;

  localparam logic [3:0] CMD_NOP = 4'd15;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 75;

  typedef struct {
    word_t      res;
    bit         c;
    bit         o;
    logic [1:0] err;
  } alu_result_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [3:0] in_command;
  word_t      in_y_operand;
  word_t      in_x_operand;
  logic       out_valid;
  word_t      out_result_word;
  logic       out_carry_out;
  logic       out_overflow_out;
  logic [1:0] out_error_code;
  logic       cfg_we;
  logic       cfg_index;
  logic [6:0] cfg_wdata;

  word_size_integer_alu dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_y_operand(in_y_operand), .in_x_operand(in_x_operand),
    .out_valid(out_valid), .out_result_word(out_result_word),
    .out_carry_out(out_carry_out), .out_overflow_out(out_overflow_out),
    .out_error_code(out_error_code),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Mirror of the configuration and the sticky flags
  logic [1:0] m_mode;
  logic [6:0] m_wsreg;
  bit         m_carry;
  bit         m_ovf;
  int         g_ws;
  word_t      g_mask;
  word_t      g_sb;

  alu_result_t expected_results[$];
  int          error_count;
  int          idle_cycles;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Derive word geometry from the word size register
  function automatic void set_geometry();
    int w;
    w = m_wsreg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    g_ws   = w;
    g_mask = (w >= 64) ? '1 : ((word_t'(1) << w) - 1);
    g_sb   = word_t'(1) << (w - 1);
  endfunction

  function automatic word_t mag_split(word_t v, output bit neg);
    v   = v & g_mask;
    neg = 1'b0;
    if (m_mode == MODE_UNS || (v & g_sb) == 0) return v;
    neg = 1'b1;
    if (m_mode == MODE_TWO) v = word_t'(0) - v;
    else if (m_mode == MODE_ONE) v = ~v;
    else v = v ^ g_sb;
    return v & g_mask;
  endfunction

  function automatic word_t mag_build(word_t m, bit neg);
    m = m & g_mask;
    if (!neg || m_mode == MODE_UNS) return m;
    if (m_mode == MODE_TWO) return (word_t'(0) - m) & g_mask;
    if (m_mode == MODE_ONE) return (~m) & g_mask;
    return m | g_sb;
  endfunction

  function automatic word_t sm_value(word_t v);
    return ((v & g_sb) != 0) ? word_t'(0) - (v ^ g_sb) : v;
  endfunction

  // Set overflow on a like-signed magnitude add
  function automatic void add_ovf(word_t xv, word_t yv, bit neg);
    word_t u;
    int    hits;
    if (m_mode == MODE_UNS) begin
      u = (yv & (g_sb - 1)) + (xv & (g_sb - 1));
      hits = int'((u & g_sb) != 0) + int'((xv & g_sb) != 0) + int'((yv & g_sb) != 0);
      if (hits > 1) m_ovf = 1'b1;
    end else if (m_mode == MODE_TWO) begin
      u = xv + yv;
      if (neg && u == g_sb) return;
      if ((u & g_sb) != 0 || (xv == g_sb && yv != 0) || (yv == g_sb && xv != 0))
        m_ovf = 1'b1;
    end else begin
      if ((g_sb & (xv + yv)) != 0) m_ovf = 1'b1;
    end
  endfunction

  function automatic word_t mul_chk(word_t a, word_t b, inout bit ov);
    word_t p;
    word_t top;
    p = (a * b) & g_mask;
    if (!ov && b != 0) begin
      top = (m_mode == MODE_UNS) ? word_t'(0) : g_sb;
      if ((p & top) != 0 || p / b != a) ov = 1'b1;
    end
    return p;
  endfunction

  function automatic word_t mul_signed(word_t y, word_t x);
    bit    sx;
    bit    sy;
    bit    ov;
    word_t mx;
    word_t my;
    word_t p;
    ov = 1'b0;
    mx = mag_split(x, sx);
    my = mag_split(y, sy);
    p  = mul_chk(my, mx, ov);
    m_ovf = ov;
    if (m_mode == MODE_UNS) return p;
    return mag_build(p & ~g_sb, sx ^ sy);
  endfunction

  function automatic word_t euclid_gcd(word_t a, word_t b);
    word_t t;
    while (b != 0) begin
      t = b;
      b = a % b;
      a = t;
    end
    return a;
  endfunction

  function automatic word_t pow_loop(word_t base, word_t e, bit ov);
    word_t p;
    bit    ov_next;
    p = 1;
    ov_next = 1'b0;
    for (int i = 0; i < g_ws && e != 0; i++) begin
      if (e[0]) begin
        if (ov_next) ov = 1'b1;
        p = mul_chk(p, base, ov);
      end
      e = e >> 1;
      if (e != 0) base = mul_chk(base, base, ov_next);
    end
    m_ovf = ov;
    return p;
  endfunction

  function automatic word_t isqrt(word_t v);
    word_t r;
    word_t b;
    r = 0;
    b = word_t'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Compute one command's result and advance the flags
  function automatic alu_result_t alu_predict(logic [3:0] cmd, word_t y_in, word_t x_in);
    alu_result_t o;
    word_t y, x, r, vx, vy, t, lim;
    bit sx, sy, rest;
    logic [1:0] err;
    set_geometry();
    err = ERR_NONE;
    r = 0;
    y = y_in & g_mask;
    x = x_in & g_mask;
    vx = mag_split(x, sx);
    vy = mag_split(y, sy);
    case (cmd)
      CMD_ADD: begin
        m_ovf = 1'b0;
        if (sx == sy) add_ovf(vx, vy, sx);
        if (m_mode == MODE_SM) begin
          m_carry = m_ovf;
          r = sm_value(y) + sm_value(x);
          if ((r & g_sb) != 0) r = (word_t'(0) - r) | g_sb;
        end else begin
          r = y + x;
          if ((r & g_mask) < y) begin
            m_carry = 1'b1;
            if (m_mode == MODE_ONE) r = r + 1;
          end else m_carry = 1'b0;
        end
      end
      CMD_SUB: begin
        m_ovf = 1'b0;
        if (sx != sy) add_ovf(vx, vy, sy);
        if (m_mode == MODE_SM) begin
          m_carry = (!sx && !sy && vx > vy) || (sx && sy && vx < vy);
          r = sm_value(y) - sm_value(x);
          if ((r & g_sb) != 0) r = (word_t'(0) - r) | g_sb;
        end else begin
          r = y - x;
          if (y < x) begin
            m_carry = 1'b1;
            if (m_mode == MODE_UNS) m_ovf = 1'b1;
            if (m_mode == MODE_ONE) r = r - 1;
          end else m_carry = 1'b0;
        end
      end
      CMD_MUL: r = mul_signed(y, x);
      CMD_DIV: begin
        if (vx == 0) err = ERR_DIV0;
        else begin
          m_ovf = 1'b0;
          t = (vy / vx) & g_mask;
          m_carry = (t * vx != vy);
          if (m_mode != MODE_UNS) begin
            if ((t & g_sb) != 0) m_carry = 1'b1;
            if (m_mode == MODE_TWO && sx && vx == 1 && y == g_sb) m_ovf = 1'b1;
          end
          r = mag_build(t, sx ^ sy);
        end
      end
      CMD_CHS: begin
        if (m_mode == MODE_UNS || (m_mode == MODE_TWO && x == g_sb)) begin
          m_ovf = 1'b1;
          r = word_t'(0) - vx;
        end else begin
          m_ovf = 1'b0;
          r = mag_build(vx, !sx);
        end
      end
      CMD_ABS: begin
        m_ovf = 1'b0;
        if (m_mode == MODE_TWO && x == g_sb) begin
          m_ovf = 1'b1;
          r = x;
        end else r = mag_build(vx, 1'b0);
      end
      CMD_SIGN: r = (vx == 0) ? word_t'(0) : mag_build(1, sx);
      CMD_GCD: begin
        if (vx == 0) t = vy;
        else if (vy == 0) t = vx;
        else t = euclid_gcd(vx, vy);
        r = mag_build(t, 1'b0);
      end
      CMD_LCM: begin
        if (vx != 0 && vy != 0) begin
          t = euclid_gcd(vx, vy);
          r = mul_signed((vx / t) & g_mask, mag_build(vy, 1'b0));
        end
      end
      CMD_SQRT: begin
        if (sx) err = ERR_DOMAIN;
        else if (vx != 0) begin
          t = isqrt(vx);
          m_carry = (t * t != vx);
          r = t;
        end
      end
      CMD_POW: begin
        if (vx == 0 && vy == 0) begin
          err = ERR_DOMAIN;
          m_ovf = 1'b1;
        end else begin
          m_carry = 1'b0;
          m_ovf = 1'b0;
          if (vx == 0) r = 1;
          else if (vy == 0) r = 0;
          else r = mag_build(pow_loop(vy, vx, 1'b0), sy && vx[0]);
        end
      end
      CMD_POW2: begin
        lim = g_ws;
        m_ovf = 1'b0;
        m_carry = (sx && vx == 1);
        if (!(sx && vx != 0)) begin
          if (m_mode != MODE_UNS) lim = lim - 1;
          if (vx >= lim) begin
            m_carry = (vx == lim);
            m_ovf = 1'b1;
            r = 0;
          end else r = word_t'(1) << vx[7:0];
        end
      end
      CMD_POW10: begin
        m_carry = 1'b0;
        if (vx == 0) begin
          m_ovf = 1'b0;
          r = 1;
        end else if (sx) begin
          m_carry = 1'b1;
        end else begin
          r = mag_build(pow_loop(10, x, g_ws <= 3 || (m_mode != MODE_UNS && g_ws == 4)),
                        1'b0);
        end
      end
      CMD_LOG2: begin
        if (vx == 0 || sx) err = ERR_DOMAIN;
        else begin
          m_carry = (vx & (vx - 1)) != 0;
          t = 0;
          vx = vx >> 1;
          while (vx != 0) begin
            t++;
            vx = vx >> 1;
          end
          r = mag_build(t, 1'b0);
        end
      end
      CMD_LOG10: begin
        rest = 1'b0;
        if (vx == 0 || sx) err = ERR_DOMAIN;
        else begin
          t = 0;
          while (vx >= 10) begin
            t++;
            if (vx % 10 != 0) rest = 1'b1;
            vx = vx / 10;
          end
          m_carry = rest || vx != 1;
          r = mag_build(t, 1'b0);
        end
      end
      default: ;
    endcase
    if (err != ERR_NONE) r = 0;
    o.res = r & g_mask;
    o.c   = m_carry;
    o.o   = m_ovf;
    o.err = err;
    return o;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    alu_result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", out_result_word, '0);
      end else begin
        e = expected_results.pop_front();
        if (out_result_word !== e.res) report_mismatch("result", out_result_word, e.res);
        if (out_carry_out !== e.c) report_mismatch("carry", out_carry_out, e.c);
        if (out_overflow_out !== e.o) report_mismatch("overflow", out_overflow_out, e.o);
        if (out_error_code !== e.err) report_mismatch("error", out_error_code, e.err);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[word_size_integer_alu] ERROR");
        $finish;
      end
    end
  end

  // Send one command beat, then maybe open a gap
  task automatic send_cmd(logic [3:0] cmd, word_t y, word_t x);
    start <= 1'b1;
    in_command <= cmd;
    in_y_operand <= y;
    in_x_operand <= x;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(alu_predict(cmd, y, x));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
    end
  endtask

  // Drain all results, then write one register
  task automatic write_reg(logic idx, logic [6:0] val);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SIGN_MODE) m_mode = val[1:0];
    else m_wsreg = val;
  endtask

  task automatic set_config(logic [1:0] mode, logic [6:0] wsz);
    write_reg(REG_SIGN_MODE, {5'd0, mode});
    write_reg(REG_WORD_SIZE, wsz);
    set_geometry();
  endtask

  function automatic word_t rand_word();
    word_t v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 11))
      0: v = 0;
      1: v = 1;
      2: v = g_sb;
      3: v = g_mask;
      4: v = g_sb - 1;
      5: v = g_sb + 1;
      6: v = $urandom_range(2, 40);
      7: v = mag_build($urandom_range(1, 40), 1'b1);
      8: v = v | ~g_mask;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) v = v | ({$urandom(), $urandom()} & ~g_mask);
    return v;
  endfunction

  task automatic test_reset_state();
    send_cmd(CMD_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1);
    send_cmd(CMD_ADD, '1, '1);
    send_cmd(CMD_SUB, 64'd0, 64'h8000_0000_0000_0000);
    send_cmd(CMD_MUL, 64'h8000_0000_0000_0000, '1);
  endtask

  task automatic test_errors();
    send_cmd(CMD_DIV, 64'd7, 64'd0);
    send_cmd(CMD_SQRT, 64'd0, '1);
    send_cmd(CMD_LOG2, 64'd0, 64'd0);
    send_cmd(CMD_LOG10, 64'd0, '1);
    send_cmd(CMD_POW, 64'd0, 64'd0);
    send_cmd(CMD_POW, 64'd3, '1);
    send_cmd(CMD_POW10, 64'd0, 64'hffff_ffff_ffff_fffd);
    send_cmd(CMD_NOP, '1, '1);
  endtask

  task automatic test_all_commands();
    set_config(MODE_SM, 7'd8);
    for (int c = 0; c < 16; c++) send_cmd(4'(c), 64'hff00_0000_0000_0085, 64'h0c);
  endtask

  task automatic test_size_clamp();
    set_config(MODE_ONE, 7'd0);
    send_cmd(CMD_ADD, 64'd1, 64'd1);
    send_cmd(CMD_POW2, 64'd0, 64'd0);
    set_config(MODE_UNS, 7'd127);
    send_cmd(CMD_ADD, '1, 64'd1);
    send_cmd(CMD_SQRT, 64'd0, '1);
  endtask

  task automatic test_random();
    logic [6:0] sizes[14] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd8, 7'd16,
                              7'd31, 7'd32, 7'd63, 7'd64, 7'd65, 7'd127};
    logic [6:0] wsz;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wsz = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                        : sizes[$urandom_range(0, 13)];
      set_config(2'($urandom_range(0, 3)), wsz);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_cmd(4'($urandom_range(0, 15)), rand_word(), rand_word());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_command <= CMD_ADD;
    in_y_operand <= '0;
    in_x_operand <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_SIGN_MODE;
    cfg_wdata <= '0;
    error_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    m_mode = MODE_TWO;
    m_wsreg = WS_RESET;
    m_carry = 1'b0;
    m_ovf = 1'b0;
    set_geometry();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_errors();
    test_all_commands();
    test_size_clamp();
    test_random();

    // Drain and settle
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("[word_size_integer_alu] OK");
    end else begin
      $display("[word_size_integer_alu] ERROR");
    end
    $finish;
  end

endmodule
